// File: rtl/core/cpt_pkg.sv
// Shared types and constants for the call pair profiler table.
package cpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W            = 32;
    localparam int COUNT_W           = 32;
    localparam int SLOT_W            = 6;
    localparam int RD_IDX_W          = 6;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int S_TDATA_W         = 80;
    localparam int M_TDATA_W         = 40;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_RECORD   = 2'd1,
        OP_READ     = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_COUNT,
        S_DONE
    } t_state;

    // Search word that walks down the row of table cells.
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] key_a;
        logic [ADDR_W-1:0] key_b;
        logic              hit_a;
        logic              hit_b;
    } t_probe;

    typedef struct packed {
        logic vld;
        logic incr;
    } t_cnt_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cnt_rsp;

endpackage

// File: rtl/core/call_pair_profiler_table.sv
// Top level of the call pair profiler table: address table row, counter matrix, control.
//
// The block keeps up to TABLE_ENTRIES function addresses in a row of cells,
// filled in order of registration, and a TABLE_ENTRIES x TABLE_ENTRIES matrix
// of saturating 32-bit call counters in one memory. tuser carries the
// operation on the input side (0 register, 1 record call, 2 read count) and
// the status on the output side (0 ok, 1 table full, 2 address not found).
// Every accepted word gives exactly one result word. One word is worked on at
// a time. A register word with a nonzero address, or a record word with a
// caller present, sends one search word down the row of cells, one cell per
// clock, comparing caller and callee keys at once; a record that finds both
// then does a counter read-modify-write. After reset the counter memory is
// swept to zero, one entry per clock, during which s_axis_tready stays low.
// Read indexes at or beyond TABLE_ENTRIES return address-not-found.
module call_pair_profiler_table
    import cpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // address[31:0], caller_address[63:32], caller_present[64],
    // from_index[70:65], to_index[76:71], zero fill [79:77]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // slot_index[5:0], call_count[37:6], zero fill [39:38]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES * TABLE_ENTRIES);

    // ---- state and latched input word ----
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_caller;
    logic                r_present;
    logic [RD_IDX_W-1:0] r_from;
    logic [RD_IDX_W-1:0] r_to;
    logic [IW:0]         r_fill, n_fill;

    // result being built, then the output register
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_vld;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [COUNT_W-1:0]  r_out_count;

    logic                w_in_acc;
    logic                w_load;
    logic                w_launch;
    logic                w_wr_en;
    logic                w_rd_ok;
    logic [IW-1:0]       w_fi;
    logic [IW-1:0]       w_ti;
    logic [CW-1:0]       w_cnt_addr;
    t_cnt_req            w_cnt_req;
    t_cnt_rsp            w_cnt_rsp;
    logic [COUNT_W-1:0]  w_cnt_val;

    // ---- row of table cells ----
    t_probe              w_probe [TABLE_ENTRIES+1];
    logic [IW-1:0]       w_idx_a [TABLE_ENTRIES+1];
    logic [IW-1:0]       w_idx_b [TABLE_ENTRIES+1];

    // register uses key_a for the new address; record uses caller / callee
    always_comb begin
        w_probe[0].vld   = w_launch;
        w_probe[0].key_a = (t_op'(r_op) == OP_REGISTER) ? r_addr : r_caller;
        w_probe[0].key_b = r_addr;
        w_probe[0].hit_a = 1'b0;
        w_probe[0].hit_b = 1'b0;
    end
    assign w_idx_a[0] = '0;
    assign w_idx_b[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        cpt_cell #(
            .IDX_W    (IW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en && (r_fill[IW-1:0] == IW'(g))),
            .i_wr_addr (r_addr),
            .i_probe   (w_probe[g]),
            .i_idx_a   (w_idx_a[g]),
            .i_idx_b   (w_idx_b[g]),
            .o_probe   (w_probe[g+1]),
            .o_idx_a   (w_idx_a[g+1]),
            .o_idx_b   (w_idx_b[g+1])
        );
    end

    // ---- counter matrix ----
    cpt_counter #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_counter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cnt_req),
        .i_addr  (w_cnt_addr),
        .o_rsp   (w_cnt_rsp),
        .o_count (w_cnt_val)
    );

    assign w_rd_ok = (int'(r_from) < TABLE_ENTRIES) && (int'(r_to) < TABLE_ENTRIES);

    // read uses the word's indexes, record the indexes found by the search
    always_comb begin
        if (r_state == S_SCAN) begin
            w_fi = w_idx_a[TABLE_ENTRIES];
            w_ti = w_idx_b[TABLE_ENTRIES];
        end else begin
            w_fi = IW'(r_from);
            w_ti = IW'(r_to);
        end
    end
    assign w_cnt_addr = CW'(w_fi) * CW'(TABLE_ENTRIES) + CW'(w_ti);

    assign s_axis_tready = (r_state == S_IDLE) && !w_cnt_rsp.busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_DONE) && (!r_out_vld || m_axis_tready);

    // ---- control ----
    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_slot    = r_slot;
        n_count   = r_count;
        n_fill    = r_fill;
        w_launch  = 1'b0;
        w_wr_en   = 1'b0;
        w_cnt_req = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_status = STAT_OK;
                    n_slot   = '0;
                    n_count  = '0;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (t_op'(r_op))
                    OP_REGISTER: begin
                        if (r_addr != '0) begin
                            w_launch = 1'b1;
                            n_state  = S_SCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_RECORD: begin
                        if (r_present) begin
                            w_launch = 1'b1;
                            n_state  = S_SCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_READ: begin
                        if (w_rd_ok) begin
                            w_cnt_req.vld = 1'b1;
                            n_state       = S_COUNT;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_probe[TABLE_ENTRIES].vld) begin
                    if (t_op'(r_op) == OP_REGISTER) begin
                        n_state = S_DONE;
                        if (w_probe[TABLE_ENTRIES].hit_a) begin
                            n_slot = SLOT_W'(w_idx_a[TABLE_ENTRIES]);
                        end else if (r_fill == (IW+1)'(TABLE_ENTRIES)) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_slot  = SLOT_W'(r_fill[IW-1:0]);
                            n_fill  = r_fill + (IW+1)'(1);
                        end
                    end else if (w_probe[TABLE_ENTRIES].hit_a
                                 && w_probe[TABLE_ENTRIES].hit_b) begin
                        w_cnt_req.vld  = 1'b1;
                        w_cnt_req.incr = 1'b1;
                        n_state        = S_COUNT;
                    end else begin
                        n_status = STAT_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_COUNT: begin
                if (w_cnt_rsp.done) begin
                    n_count = w_cnt_val;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= s_axis_tuser;
            r_addr    <= s_axis_tdata[31:0];
            r_caller  <= s_axis_tdata[63:32];
            r_present <= s_axis_tdata[64];
            r_from    <= s_axis_tdata[70:65];
            r_to      <= s_axis_tdata[76:71];
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_count  <= n_count;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_slot   <= r_slot;
            r_out_count  <= r_count;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_slot};
    assign m_axis_tuser  = r_out_status;

endmodule

// File: rtl/core/cpt_cell.sv
// One address table cell: holds one entry and compares the passing search word.
module cpt_cell
    import cpt_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_probe            i_probe,
    input  logic [IDX_W-1:0]  i_idx_a,
    input  logic [IDX_W-1:0]  i_idx_b,
    output t_probe            o_probe,
    output logic [IDX_W-1:0]  o_idx_a,
    output logic [IDX_W-1:0]  o_idx_b
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_entry;
    t_probe            r_probe;
    t_probe            n_probe;
    logic [IDX_W-1:0]  r_idx_a;
    logic [IDX_W-1:0]  r_idx_b;
    logic [IDX_W-1:0]  n_idx_a;
    logic [IDX_W-1:0]  n_idx_b;
    logic              w_match_a;
    logic              w_match_b;

    // stored entries are never zero, so a zero key never matches
    assign w_match_a = r_valid && (r_entry == i_probe.key_a);
    assign w_match_b = r_valid && (r_entry == i_probe.key_b);

    always_comb begin
        n_probe = i_probe;
        n_idx_a = i_idx_a;
        n_idx_b = i_idx_b;
        if (w_match_a && !i_probe.hit_a) begin
            n_probe.hit_a = 1'b1;
            n_idx_a       = IDX_W'(CELL_IDX);
        end
        if (w_match_b && !i_probe.hit_b) begin
            n_probe.hit_b = 1'b1;
            n_idx_b       = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_probe.vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid <= 1'b1;
            end
            r_probe.vld <= n_probe.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_addr;
        end
        r_probe.key_a <= n_probe.key_a;
        r_probe.key_b <= n_probe.key_b;
        r_probe.hit_a <= n_probe.hit_a;
        r_probe.hit_b <= n_probe.hit_b;
        r_idx_a       <= n_idx_a;
        r_idx_b       <= n_idx_b;
    end

    assign o_probe = r_probe;
    assign o_idx_a = r_idx_a;
    assign o_idx_b = r_idx_b;

endmodule

// File: rtl/core/cpt_counter.sv
// Call counter matrix: clear sweep after reset and saturating read-modify-write.
module cpt_counter
    import cpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_cnt_req                                  i_req,
    input  logic [$clog2(TABLE_ENTRIES*TABLE_ENTRIES)-1:0] i_addr,
    output t_cnt_rsp                                  o_rsp,
    output logic [COUNT_W-1:0]                        o_count
);

    localparam int DEPTH = TABLE_ENTRIES * TABLE_ENTRIES;
    localparam int CW    = $clog2(DEPTH);

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic               r_clearing;
    logic [CW-1:0]      r_clr_addr;
    logic               r_pend;
    logic               r_incr;
    logic [CW-1:0]      r_addr;
    logic [COUNT_W-1:0] r_rd_data;
    logic [COUNT_W-1:0] w_new;

    // saturate at all ones
    assign w_new = (r_incr && (r_rd_data != '1)) ? r_rd_data + COUNT_W'(1) : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_pend <= i_req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_pend && r_incr) begin
            r_mem[r_addr] <= w_new;
        end
        if (i_req.vld) begin
            r_rd_data <= r_mem[i_addr];
            r_addr    <= i_addr;
            r_incr    <= i_req.incr;
        end
    end

    assign o_rsp.busy = r_clearing;
    assign o_rsp.done = r_pend;
    assign o_count    = w_new;

endmodule

// File: rtl/core/cpt_checker.sv
// Port-level checks for the call pair profiler table, bound to the top level.
module cpt_checker
    import cpt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL
                           || m_axis_tuser == STAT_NOT_FOUND))
        else $error("result with an unused status code");

    // a failing word carries neither a slot nor a count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
        else $error("failing result carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind call_pair_profiler_table cpt_checker u_cpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
